// ===== rtl/bsfc_pkg.sv =====
`timescale 1ns / 1ps

package bsfc_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 16;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned MAX_RES         = 3;
  localparam int unsigned RES_CNT_W       = 2;
  localparam int unsigned OUT_TDATA_W     = 32;
  localparam int unsigned LENGTH_BITS_DEF = 16;

  localparam logic [BYTE_W-1:0] FLAG_BYTE_RST   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd125;
  localparam logic [BYTE_W-1:0] FLAG_SUB_RST    = 8'd2;
  localparam logic [BYTE_W-1:0] ESC_SUB_RST     = 8'd1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FLAG_BYTE   = 3'd0,
    CFG_ESCAPE_BYTE = 3'd1,
    CFG_FLAG_SUB    = 3'd2,
    CFG_ESC_SUB     = 3'd3,
    CFG_UNPACK_MODE = 3'd4
  } cfg_addr_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_STRAY_FLAG = 2'd1,
    ST_BAD_ESC    = 2'd2,
    ST_TRUNC_ESC  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] flag_sub;
    logic [BYTE_W-1:0] esc_sub;
    logic              unpack_mode;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    kind_e             kind;
    status_e           status;
    logic [LEN_W-1:0]  len;
    logic              last;
  } res_t;

endpackage

// ===== rtl/bsfc_cfg_regs.sv =====
`timescale 1ns / 1ps

module bsfc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bsfc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [bsfc_pkg::BYTE_W-1:0]       cfg_wdata_i,
  output bsfc_pkg::cfg_t                    cfg_o
);
  import bsfc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte   <= FLAG_BYTE_RST;
      cfg_q.escape_byte <= ESCAPE_BYTE_RST;
      cfg_q.flag_sub    <= FLAG_SUB_RST;
      cfg_q.esc_sub     <= ESC_SUB_RST;
      cfg_q.unpack_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_e'(cfg_addr_i))
        CFG_FLAG_BYTE:   cfg_q.flag_byte   <= cfg_wdata_i;
        CFG_ESCAPE_BYTE: cfg_q.escape_byte <= cfg_wdata_i;
        CFG_FLAG_SUB:    cfg_q.flag_sub    <= cfg_wdata_i;
        CFG_ESC_SUB:     cfg_q.esc_sub     <= cfg_wdata_i;
        CFG_UNPACK_MODE: cfg_q.unpack_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bsfc_in_stage.sv =====
`timescale 1ns / 1ps

module bsfc_in_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bsfc_pkg::item_t              item_i,
  input  logic                         drain_i,   // expander takes the held word
  output logic                         full_o,
  output bsfc_pkg::item_t              item_o
);
  import bsfc_pkg::*;

  logic  full_q, full_d;
  item_t item_q;
  logic  fire;

  assign in_ready_o = !full_q || drain_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    full_d = full_q;
    if (fire) begin
      full_d = 1'b1;
    end else if (drain_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= item_i;
    end
  end

  assign full_o = full_q;
  assign item_o = item_q;

endmodule

// ===== rtl/bsfc_expand.sv =====
`timescale 1ns / 1ps

module bsfc_expand #(
  parameter int unsigned LENGTH_BITS = bsfc_pkg::LENGTH_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  bsfc_pkg::cfg_t                            cfg_i,
  input  bsfc_pkg::item_t                           item_i,
  input  logic                                      take_i,
  output bsfc_pkg::res_t [bsfc_pkg::MAX_RES-1:0]    res_o,
  output logic [bsfc_pkg::RES_CNT_W-1:0]            n_res_o
);
  import bsfc_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  logic                    in_frame_q, in_frame_d;
  logic                    esc_pend_q, esc_pend_d;
  status_e                 err_q, err_d;
  logic [LENGTH_BITS-1:0]  count_q, count_d;

  logic [BYTE_W-1:0]       byte_v [MAX_RES];
  logic [RES_CNT_W-1:0]    nb;
  logic [RES_CNT_W-1:0]    n_res;
  logic [LENGTH_BITS+1:0]  sum_raw;
  logic [LENGTH_BITS-1:0]  count_sum;
  status_e                 st;
  res_t [MAX_RES-1:0]      res;

  // byte list for one word, then saturating count and result records
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      byte_v[i] = '0;
    end
    nb         = '0;
    in_frame_d = in_frame_q;
    esc_pend_d = esc_pend_q;
    err_d      = err_q;

    if (item_i.cmd == CMD_DATA) begin
      in_frame_d = 1'b1;
      if (!cfg_i.unpack_mode) begin
        if (!in_frame_q) begin
          byte_v[nb] = cfg_i.flag_byte;
          nb         = nb + 1'b1;
        end
        // flag test wins when flag and escape values coincide
        if (item_i.data == cfg_i.flag_byte) begin
          byte_v[nb] = cfg_i.escape_byte;
          nb         = nb + 1'b1;
          byte_v[nb] = cfg_i.flag_sub;
          nb         = nb + 1'b1;
        end else if (item_i.data == cfg_i.escape_byte) begin
          byte_v[nb] = cfg_i.escape_byte;
          nb         = nb + 1'b1;
          byte_v[nb] = cfg_i.esc_sub;
          nb         = nb + 1'b1;
        end else begin
          byte_v[nb] = item_i.data;
          nb         = nb + 1'b1;
        end
      end else begin
        if (err_q != ST_OK) begin
          esc_pend_d = 1'b0;
        end else if (esc_pend_q) begin
          esc_pend_d = 1'b0;
          if (item_i.data == cfg_i.flag_sub) begin
            byte_v[nb] = cfg_i.flag_byte;
            nb         = nb + 1'b1;
          end else if (item_i.data == cfg_i.esc_sub) begin
            byte_v[nb] = cfg_i.escape_byte;
            nb         = nb + 1'b1;
          end else begin
            err_d = ST_BAD_ESC;
          end
        end else if (item_i.data == cfg_i.escape_byte) begin
          esc_pend_d = 1'b1;
        end else if (item_i.data == cfg_i.flag_byte) begin
          err_d = ST_STRAY_FLAG;
        end else begin
          byte_v[nb] = item_i.data;
          nb         = nb + 1'b1;
        end
      end
    end else begin
      if (!cfg_i.unpack_mode) begin
        if (!in_frame_q) begin
          byte_v[nb] = cfg_i.flag_byte;
          nb         = nb + 1'b1;
        end
        byte_v[nb] = cfg_i.flag_byte;
        nb         = nb + 1'b1;
      end
      in_frame_d = 1'b0;
      esc_pend_d = 1'b0;
      err_d      = ST_OK;
    end

    sum_raw = {2'b00, count_q} + (LENGTH_BITS+2)'(nb);
    if (sum_raw[LENGTH_BITS+1:LENGTH_BITS] != 2'b00) begin
      count_sum = LEN_MAX;
    end else begin
      count_sum = sum_raw[LENGTH_BITS-1:0];
    end
    count_d = (item_i.cmd == CMD_END) ? '0 : count_sum;

    st = err_q;
    if (st == ST_OK && esc_pend_q) begin
      st = ST_TRUNC_ESC;
    end

    for (int i = 0; i < MAX_RES; i++) begin
      res[i]      = '0;
      res[i].data = byte_v[i];
    end
    n_res = nb;
    if (item_i.cmd == CMD_END) begin
      res[nb].data   = '0;
      res[nb].kind   = KIND_REPORT;
      res[nb].status = st;
      res[nb].len    = LEN_W'(count_sum);
      n_res          = nb + 1'b1;
    end
    if (n_res != '0) begin
      res[n_res - 1'b1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_pend_q <= 1'b0;
      err_q      <= ST_OK;
      count_q    <= '0;
    end else if (take_i) begin
      in_frame_q <= in_frame_d;
      esc_pend_q <= esc_pend_d;
      err_q      <= err_d;
      count_q    <= count_d;
    end
  end

  assign res_o   = res;
  assign n_res_o = n_res;

endmodule

// ===== rtl/bsfc_out_queue.sv =====
`timescale 1ns / 1ps

module bsfc_out_queue (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      load_i,
  input  bsfc_pkg::res_t [bsfc_pkg::MAX_RES-1:0]    res_i,
  input  logic [bsfc_pkg::RES_CNT_W-1:0]            n_res_i,
  output logic                                      load_rdy_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output bsfc_pkg::res_t                            out_res_o
);
  import bsfc_pkg::*;

  res_t [MAX_RES-1:0]    res_q;
  logic [RES_CNT_W-1:0]  cnt_q;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // room for a new batch once the last held result leaves this cycle
  assign load_rdy_o  = (cnt_q == '0) || ((cnt_q == RES_CNT_W'(1)) && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= n_res_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end else if (pop) begin
      res_q <= {res_t'('0), res_q[MAX_RES-1:1]};
    end
  end

  assign out_res_o = res_q[0];

endmodule

// ===== rtl/byte_stuffing_frame_codec.sv =====
`timescale 1ns / 1ps

// Flow: an accepted word waits in the input register until the result queue can take its
// batch; the batch is then loaded into the queue, whose head is offered on m_axis.
// Throughput: one result per cycle while m_axis_tready is high; a word expands to at most
// three results, and the next word is held in the input register while a batch drains.
// Reset (async, active low) clears frame state and queues; config registers
// return to flag 126, escape 125, substitutes 2 and 1, pack mode.
module byte_stuffing_frame_codec #(
  parameter int unsigned LENGTH_BITS = bsfc_pkg::LENGTH_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write port
  input  logic                                  cfg_we_i,
  input  logic [bsfc_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [bsfc_pkg::BYTE_W-1:0]           cfg_wdata_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [bsfc_pkg::BYTE_W-1:0]           s_axis_tdata,  // [7:0] data_in
  input  logic                                  s_axis_tuser,  // [0] cmd
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] data_out, [9:8] status, [25:10] frame_length, [31:26] zero
  output logic [bsfc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tuser,  // [0] kind
  output logic                                  m_axis_tlast   // last_of_run
);
  import bsfc_pkg::*;

  localparam int unsigned PAD_W = OUT_TDATA_W - BYTE_W - 2 - LEN_W;

  cfg_t                  cfg;
  item_t                 s_item;
  item_t                 held_item;
  logic                  held_full;
  logic                  load_rdy;
  logic                  take;
  res_t [MAX_RES-1:0]    batch;
  logic [RES_CNT_W-1:0]  batch_n;
  res_t                  out_res;

  assign s_item.cmd  = cmd_e'(s_axis_tuser);
  assign s_item.data = s_axis_tdata;

  bsfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register; it refills in the same cycle the expander drains it.
  bsfc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .item_i     (s_item),
    .drain_i    (take),
    .full_o     (held_full),
    .item_o     (held_item)
  );

  // A held word is decoded and committed when the result queue can take its batch.
  assign take = held_full && load_rdy;

  bsfc_expand #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_expand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .item_i  (held_item),
    .take_i  (take),
    .res_o   (batch),
    .n_res_o (batch_n)
  );

  bsfc_out_queue u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (batch),
    .n_res_i     (batch_n),
    .load_rdy_o  (load_rdy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_res.len, out_res.status, out_res.data};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== rtl/bsfc_checker.sv =====
`timescale 1ns / 1ps

module bsfc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [bsfc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                               m_axis_tuser,
  input logic                               m_axis_tlast
);
  import bsfc_pkg::*;

  // stalled word must stay offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // a frame report always closes the run of its word
  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_REPORT) |-> m_axis_tlast)
    else $error("frame report without tlast");

  a_report_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_REPORT) |-> (m_axis_tdata[7:0] == '0))
    else $error("frame report carries a data byte");

  a_byte_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_BYTE) |-> (m_axis_tdata[31:8] == '0))
    else $error("byte word carries status or length");

endmodule

bind byte_stuffing_frame_codec bsfc_checker u_bsfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Byte-stuffing codec bench: directed table, then random phases that re-program the
// codec between phases, then a short back-to-back pack frame with no idling.
module tb;
  import bsfc_pkg::*;

  localparam int unsigned WATCHDOG = 2000;  // cycles with no activity at all
  localparam int unsigned HOLD_CYC = 300;   // long receiver hold-off
  localparam int unsigned SETTLE   = 8;     // lets in-flight work settle after the last owed word
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // ---------------------------------------------------------------- DUT signals
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [BYTE_W-1:0]      cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;   // [7:0] data_in
  logic                   s_axis_tuser  = 1'b0; // [0] cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] data, [9:8] status, [25:10] len
  logic                   m_axis_tuser;         // [0] kind
  logic                   m_axis_tlast;         // last word of the run

  byte_stuffing_frame_codec uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- bench state
  bit          idle_on  = 1'b1;  // random gaps / stalls enabled
  bit          hold_req = 1'b0;  // ask receiver for one long hold-off
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cyc  = 0;
  int unsigned fail_cnt   = 0;
  int unsigned words_in   = 0;
  int unsigned words_out  = 0;
  int unsigned reports    = 0;
  int unsigned bad_frames = 0;

  // codec shadow: config, frame state, and the words it should emit
  cfg_t             codec_cfg;
  logic             in_frame;
  logic             esc_pend;
  status_e          frame_err;
  logic [LEN_W-1:0] emit_cnt;
  res_t             run_buf [MAX_RES];
  int unsigned      run_n;
  res_t             out_words_q [$];
  res_t             last_report;

  // directed table row: either a register write or one input word
  typedef struct packed {
    logic             is_reg;
    cfg_addr_e        reg_sel;
    logic [BYTE_W-1:0] value;   // register value or data byte
    cmd_e             cmd;
    logic             chk;      // typed report check on an end-of-frame row
    status_e          st;
    logic [LEN_W-1:0] len;
  } step_t;

  step_t dir_rows [$];

  // ---------------------------------------------------------------- codec shadow
  task automatic add_word(input logic [BYTE_W-1:0] d, input kind_e k, input status_e st,
                          input logic [LEN_W-1:0] len);
    res_t r;
    r.data   = d;
    r.kind   = k;
    r.status = st;
    r.len    = len;
    r.last   = 1'b0;
    run_buf[run_n] = r;
    run_n++;
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] d);
    add_word(d, KIND_BYTE, ST_OK, '0);
    if (emit_cnt != LEN_SAT) emit_cnt++;
  endtask

  // Works out the words one accepted input causes and queues them.
  task automatic codec_step(input cmd_e c, input logic [BYTE_W-1:0] b);
    status_e st;
    res_t    r;
    run_n = 0;
    if (c == CMD_DATA) begin
      if (!codec_cfg.unpack_mode) begin
        if (!in_frame) begin
          add_byte(codec_cfg.flag_byte);
          in_frame = 1'b1;
        end
        // flag test first: it wins when flag and escape are the same value
        if (b == codec_cfg.flag_byte) begin
          add_byte(codec_cfg.escape_byte);
          add_byte(codec_cfg.flag_sub);
        end else if (b == codec_cfg.escape_byte) begin
          add_byte(codec_cfg.escape_byte);
          add_byte(codec_cfg.esc_sub);
        end else begin
          add_byte(b);
        end
      end else begin
        in_frame = 1'b1;
        if (frame_err != ST_OK) begin
          esc_pend = 1'b0;  // frame already broken: drop silently
        end else if (esc_pend) begin
          esc_pend = 1'b0;
          if (b == codec_cfg.flag_sub) add_byte(codec_cfg.flag_byte);
          else if (b == codec_cfg.esc_sub) add_byte(codec_cfg.escape_byte);
          else frame_err = ST_BAD_ESC;
        end else if (b == codec_cfg.escape_byte) begin
          esc_pend = 1'b1;  // escape wins over flag in unpack mode
        end else if (b == codec_cfg.flag_byte) begin
          frame_err = ST_STRAY_FLAG;
        end else begin
          add_byte(b);
        end
      end
    end else begin
      if (!codec_cfg.unpack_mode) begin
        if (!in_frame) add_byte(codec_cfg.flag_byte);
        add_byte(codec_cfg.flag_byte);
      end
      st = frame_err;
      if (st == ST_OK && esc_pend) st = ST_TRUNC_ESC;
      add_word('0, KIND_REPORT, st, emit_cnt);
      last_report = run_buf[run_n-1];
      in_frame  = 1'b0;
      esc_pend  = 1'b0;
      frame_err = ST_OK;
      emit_cnt  = '0;
    end
    for (int i = 0; i < run_n; i++) begin
      r = run_buf[i];
      r.last = (i == run_n - 1);
      out_words_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- monitor
  // Input side is predicted before the output side is checked in the same edge.
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      codec_cfg.flag_byte   = FLAG_BYTE_RST;
      codec_cfg.escape_byte = ESCAPE_BYTE_RST;
      codec_cfg.flag_sub    = FLAG_SUB_RST;
      codec_cfg.esc_sub     = ESC_SUB_RST;
      codec_cfg.unpack_mode = 1'b0;
      in_frame  = 1'b0;
      esc_pend  = 1'b0;
      frame_err = ST_OK;
      emit_cnt  = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_FLAG_BYTE:   codec_cfg.flag_byte   = cfg_wdata_i;
          CFG_ESCAPE_BYTE: codec_cfg.escape_byte = cfg_wdata_i;
          CFG_FLAG_SUB:    codec_cfg.flag_sub    = cfg_wdata_i;
          CFG_ESC_SUB:     codec_cfg.esc_sub     = cfg_wdata_i;
          CFG_UNPACK_MODE: codec_cfg.unpack_mode = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        codec_step(cmd_e'(s_axis_tuser), s_axis_tdata);
        words_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.data   = m_axis_tdata[7:0];
        got.status = status_e'(m_axis_tdata[9:8]);
        got.len    = m_axis_tdata[25:10];
        got.kind   = kind_e'(m_axis_tuser);
        got.last   = m_axis_tlast;
        words_out++;
        if (got.kind == KIND_REPORT) begin
          reports++;
          if (got.status != ST_OK) bad_frames++;
        end
        if (out_words_q.size() == 0) begin
          $display("%0t: unexpected word: data=%h kind=%0d st=%0d len=%0d last=%0d", $time,
                   got.data, got.kind, got.status, got.len, got.last);
          fail_cnt++;
        end else begin
          want = out_words_q.pop_front();
          if (got.data !== want.data || got.kind !== want.kind ||
              got.status !== want.status || got.len !== want.len ||
              got.last !== want.last) begin
            $display("%0t: mismatch exp data=%h kind=%0d st=%0d len=%0d last=%0d", $time,
                     want.data, want.kind, want.status, want.len, want.last);
            $display("%0t:          got data=%h kind=%0d st=%0d len=%0d last=%0d", $time,
                     got.data, got.kind, got.status, got.len, got.last);
            fail_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
  end

  initial begin
    while (quiet_cyc < WATCHDOG) @(posedge clk_i);
    $display("%0t: watchdog expired, %0d words still owed", $time, out_words_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // One assignment to tready per falling edge; long hold-off has priority.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 18);  // random-length stall burst
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sender
  // Entered and left at a falling edge; tvalid stays high between back-to-back words.
  task automatic send_word(input cmd_e c, input logic [BYTE_W-1:0] d);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Wait until every owed word has come out, then let in-flight work settle.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (out_words_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_addr_e a, input logic [BYTE_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= a;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] rand_reg_byte(input logic [BYTE_W-1:0] rst_val);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return rst_val;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed content; unpack side gets valid escape pairs plus some breakage.
  task automatic send_random_word();
    int unsigned       pick;
    logic [BYTE_W-1:0] b;
    pick = $urandom_range(0, 99);
    b    = BYTE_W'($urandom_range(0, 255));
    if (pick < 10) begin
      send_word(CMD_END, b);
    end else if (!codec_cfg.unpack_mode) begin
      if (pick < 25) b = codec_cfg.flag_byte;
      else if (pick < 40) b = codec_cfg.escape_byte;
      send_word(CMD_DATA, b);
    end else if (pick < 72) begin
      send_word(CMD_DATA, b);
    end else if (pick < 92) begin
      send_word(CMD_DATA, codec_cfg.escape_byte);
      send_word(CMD_DATA, pick[0] ? codec_cfg.flag_sub : codec_cfg.esc_sub);
    end else if (pick < 95) begin
      send_word(CMD_DATA, codec_cfg.flag_byte);  // stray flag
    end else begin
      send_word(CMD_DATA, codec_cfg.escape_byte);
      send_word(CMD_DATA, b);                    // likely a bad escape
    end
  endtask

  // ---------------------------------------------------------------- directed table
  task automatic row_data(input logic [BYTE_W-1:0] b);
    dir_rows.push_back({1'b0, CFG_FLAG_BYTE, b, CMD_DATA, 1'b0, ST_OK, 16'd0});
  endtask

  task automatic row_end(input logic [BYTE_W-1:0] b, input status_e st,
                         input logic [LEN_W-1:0] len);
    dir_rows.push_back({1'b0, CFG_FLAG_BYTE, b, CMD_END, 1'b1, st, len});
  endtask

  task automatic row_reg(input cfg_addr_e a, input logic [BYTE_W-1:0] v);
    dir_rows.push_back({1'b1, a, v, CMD_DATA, 1'b0, ST_OK, 16'd0});
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    step_t             s;
    logic [BYTE_W-1:0] fb, eb, fs, es;

    // reset-default pack mode: empty frame, byte extremes, both stuffed values
    row_end(8'hFF, ST_OK, 16'd2);
    row_data(8'h00);
    row_data(8'hFF);
    row_data(8'd126);
    row_data(8'd125);
    row_end(8'h00, ST_OK, 16'd8);
    // unpack: clean frame with both escape pairs
    row_reg(CFG_UNPACK_MODE, 8'd1);
    row_data(8'h41);
    row_data(8'd125);
    row_data(8'd2);
    row_data(8'd125);
    row_data(8'd1);
    row_end(8'h00, ST_OK, 16'd3);
    // stray flag, then the rest of the frame is dropped
    row_data(8'd126);
    row_data(8'h55);
    row_end(8'h00, ST_STRAY_FLAG, 16'd0);
    // escape followed by a byte that is neither substitute
    row_data(8'd125);
    row_data(8'h33);
    row_end(8'h00, ST_BAD_ESC, 16'd0);
    // escape still open at frame end
    row_data(8'd125);
    row_end(8'h00, ST_TRUNC_ESC, 16'd0);
    // flag == escape and equal substitutes, pack then unpack
    row_reg(CFG_FLAG_BYTE, 8'h00);
    row_reg(CFG_ESCAPE_BYTE, 8'h00);
    row_reg(CFG_FLAG_SUB, 8'hFF);
    row_reg(CFG_ESC_SUB, 8'hFF);
    row_reg(CFG_UNPACK_MODE, 8'd0);
    row_data(8'h00);
    row_end(8'h00, ST_OK, 16'd4);
    row_reg(CFG_UNPACK_MODE, 8'd1);
    row_data(8'h00);
    row_data(8'hFF);
    row_end(8'h00, ST_OK, 16'd1);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      s = dir_rows[i];
      if (s.is_reg) begin
        drain_block();
        write_reg(s.reg_sel, s.value);
      end else begin
        send_word(s.cmd, s.value);
        if (s.chk && (last_report.status !== s.st || last_report.len !== s.len)) begin
          $display("%0t: row %0d report exp st=%0d len=%0d, got st=%0d len=%0d", $time, i,
                   s.st, s.len, last_report.status, last_report.len);
          fail_cnt++;
        end
      end
    end

    // random phases; frames may stay open across a re-program
    for (int ph = 0; ph < 7; ph++) begin
      drain_block();
      fb = rand_reg_byte(FLAG_BYTE_RST);
      eb = rand_reg_byte(ESCAPE_BYTE_RST);
      fs = rand_reg_byte(FLAG_SUB_RST);
      es = rand_reg_byte(ESC_SUB_RST);
      if ($urandom_range(0, 5) == 0) eb = fb;
      if ($urandom_range(0, 5) == 0) es = fs;
      if (ph == 1) begin
        fb = '0;
        eb = '1;
        fs = '1;
        es = '0;
      end
      write_reg(CFG_FLAG_BYTE, fb);
      write_reg(CFG_ESCAPE_BYTE, eb);
      write_reg(CFG_FLAG_SUB, fs);
      write_reg(CFG_ESC_SUB, es);
      write_reg(CFG_UNPACK_MODE, {7'd0, ph[0]});
      idle_on = (ph != 2);
      repeat (8) send_random_word();
      if (ph == 3) begin
        hold_req = 1'b1;  // receiver blocks, sender keeps pushing until backpressure
        repeat (12) send_random_word();
      end
      if (ph == 4) begin
        drain_block();    // sender pause until everything is out
        repeat (6) send_random_word();
      end
    end

    // last part, no idling: a short back-to-back pack frame with both stuffed values
    idle_on = 1'b0;
    drain_block();
    while (stall_left != 0 || hold_left != 0) @(negedge clk_i);
    write_reg(CFG_FLAG_BYTE, FLAG_BYTE_RST);
    write_reg(CFG_ESCAPE_BYTE, ESCAPE_BYTE_RST);
    write_reg(CFG_UNPACK_MODE, 8'd0);
    send_word(CMD_END, 8'h00);  // close whatever frame is still open
    send_word(CMD_DATA, FLAG_BYTE_RST);
    send_word(CMD_DATA, 8'h3C);
    send_word(CMD_DATA, ESCAPE_BYTE_RST);
    send_word(CMD_END, 8'h00);
    if (last_report.status !== ST_OK || last_report.len !== 16'd7) begin
      $display("%0t: last frame exp st=%0d len=%0d got st=%0d len=%0d", $time,
               ST_OK, 16'd7, last_report.status, last_report.len);
      fail_cnt++;
    end

    drain_block();
    repeat (20) @(negedge clk_i);

    $display("Covered %0d input words, %0d output words, %0d frame reports (%0d in error).",
             words_in, words_out, reports, bad_frames);
    $display("Both modes, tied and extreme codes, stalls and a long backpressure hold hit.");
    if (fail_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bsfc_pkg.sv
rtl/bsfc_cfg_regs.sv
rtl/bsfc_in_stage.sv
rtl/bsfc_expand.sv
rtl/bsfc_out_queue.sv
rtl/byte_stuffing_frame_codec.sv
rtl/bsfc_checker.sv
tb/tb.sv
